// ----- hdl/structural_rank_matching_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Structural rank matching unit: assertion macros
// Concurrent checks that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef STRUCTURAL_RANK_MATCHING_UNIT_DEFINES_SVH
`define STRUCTURAL_RANK_MATCHING_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define SRM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset
`define SRM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SRM_ASSERT_IMP(label, ante, cons, msg)
`define SRM_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ----- hdl/srm_pkg.sv -----
// ---------------------------------------------------------------------------
// Structural rank matching package
// Widths, beat types and helpers shared by the matching unit.
// ---------------------------------------------------------------------------
package srm_pkg;

  localparam int unsigned MaxSize = 64;
  localparam int unsigned IdxW    = $clog2(MaxSize);
  localparam int unsigned CntW    = $clog2(MaxSize + 1);

  typedef struct packed {
    logic [IdxW-1:0] row_index;
    logic [IdxW-1:0] column_index;
    logic            entry_nonzero;
    logic            last_entry;
  } in_beat_t;

  typedef struct packed {
    logic [CntW-1:0] rank;
    logic [CntW-1:0] deficiency;
    logic            full_rank;
  } out_beat_t;

  // Position of the lowest set bit of a row mask
  function automatic logic [IdxW-1:0] lowest_bit(input logic [MaxSize-1:0] mask);
    logic [IdxW-1:0] idx;
    idx = '0;
    for (int i = MaxSize - 1; i >= 0; i--) begin
      if (mask[i]) idx = IdxW'(i);
    end
    return idx;
  endfunction

endpackage

// ----- hdl/structural_rank_matching_unit.sv -----
// ---------------------------------------------------------------------------
// Structural rank matching unit
// Loads a square nonzero pattern one entry a beat and, on the last entry,
// finds a maximum row-column matching by augmenting-path search.
// ---------------------------------------------------------------------------
//  channel | dir | handshake               | beat
//  in      | in  | in_valid_i / in_ready_o | row, column, nonzero, last
//  out     | out | out_valid_o/ out_ready_i| rank, deficiency, full_rank
//  cfg     | in  | cfg_valid_i/ cfg_ready_o| matrix_size (7 bits)
//
// Pattern entries are taken one per cycle while idle; a row's bits sit in a
// 64x64 memory with a valid flag per row; a result clears only the flags.
// After the last entry the sequencer tries each row as a root once; a root
// is started in ST_ROOT, each row popped passes ST_POP, ST_RDQ, ST_RDP and
// ST_SCAN, each column reached ST_SCAN and ST_CHK, and an augmentation walks
// its path back through ST_AUGA, ST_AUGB and ST_AUGC for each edge.
// Input is held off during the search; reset needs no clearing pass.
// The result register lets the next load start while a result waits.
// ---------------------------------------------------------------------------
module structural_rank_matching_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  srm_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output srm_pkg::out_beat_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [srm_pkg::CntW-1:0] cfg_data_i
);
  import srm_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_ROOT = 11'b000_0000_0010,
    ST_POP  = 11'b000_0000_0100,
    ST_RDQ  = 11'b000_0000_1000,
    ST_RDP  = 11'b000_0001_0000,
    ST_SCAN = 11'b000_0010_0000,
    ST_CHK  = 11'b000_0100_0000,
    ST_AUGA = 11'b000_1000_0000,
    ST_AUGB = 11'b001_0000_0000,
    ST_AUGC = 11'b010_0000_0000,
    ST_DONE = 11'b100_0000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     size_q;
  logic [CntW-1:0]     eff_n;
  logic [CntW-1:0]     n_q;
  logic [MaxSize-1:0]  sz_mask_q;
  logic [CntW-1:0]     root_q;
  logic [CntW-1:0]     head_q;
  logic [CntW-1:0]     tail_q;
  logic [CntW-1:0]     rank_q;
  logic [IdxW-1:0]     cur_row_q;
  logic [IdxW-1:0]     col_q;
  logic [MaxSize-1:0]  mask_q;
  logic [MaxSize-1:0]  vis_q;
  logic [MaxSize-1:0]  row_vld_q;
  logic [MaxSize-1:0]  col_vld_q;
  logic                out_vld_q;
  out_beat_t           out_q;
  logic                in_acc;
  logic                pat_we;
  logic [IdxW-1:0]     scan_col;

  // Memories and their registered read data
  logic [MaxSize-1:0]  pat_mem [MaxSize];
  logic [MaxSize-1:0]  pat_rd_q;
  logic [IdxW-1:0]     que_mem [MaxSize];
  logic [IdxW-1:0]     que_rd_q;
  logic [IdxW-1:0]     par_mem [MaxSize];
  logic [IdxW-1:0]     par_rd_q;
  logic [IdxW-1:0]     colm_mem [MaxSize];
  logic [IdxW-1:0]     colm_rd_q;
  logic [IdxW-1:0]     rowm_mem [MaxSize];
  logic [IdxW-1:0]     rowm_rd_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign in_acc      = in_valid_i & in_ready_o;
  assign eff_n       = (size_q > CntW'(MaxSize)) ? CntW'(MaxSize) : size_q;
  assign pat_we      = in_acc & in_data_i.entry_nonzero &
                       ({1'b0, in_data_i.row_index} < eff_n) &
                       ({1'b0, in_data_i.column_index} < eff_n);
  assign scan_col    = lowest_bit(mask_q);

  // Size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= CntW'(MaxSize);
    end else if (cfg_valid_i) begin
      size_q <= cfg_data_i;
    end
  end

  // Pattern memory: first bit of a row overwrites stale contents
  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      if (row_vld_q[in_data_i.row_index]) begin
        pat_mem[in_data_i.row_index][in_data_i.column_index] <= 1'b1;
      end else begin
        pat_mem[in_data_i.row_index] <= MaxSize'(1) << in_data_i.column_index;
      end
    end
    if (state_q == ST_RDQ) pat_rd_q <= pat_mem[que_rd_q];
  end

  // Search queue of rows
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROOT) begin
      que_mem[0] <= root_q[IdxW-1:0];
    end else if (state_q == ST_CHK && col_vld_q[col_q]) begin
      que_mem[tail_q[IdxW-1:0]] <= colm_rd_q;
    end
    if (state_q == ST_POP) que_rd_q <= que_mem[head_q[IdxW-1:0]];
  end

  // Parent row of each reached column
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN && mask_q != '0) par_mem[scan_col] <= cur_row_q;
    if (state_q == ST_AUGA) par_rd_q <= par_mem[col_q];
  end

  // Column and row partners
  always_ff @(posedge clk_i) begin
    if (state_q == ST_AUGC) colm_mem[col_q] <= par_rd_q;
    if (state_q == ST_SCAN) colm_rd_q <= colm_mem[scan_col];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_AUGC) rowm_mem[par_rd_q] <= col_q;
    if (state_q == ST_AUGB) rowm_rd_q <= rowm_mem[par_rd_q];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc && in_data_i.last_entry) state_d = ST_ROOT;
      ST_ROOT: state_d = (root_q >= n_q) ? ST_DONE : ST_POP;
      ST_POP:  state_d = (head_q == tail_q) ? ST_ROOT : ST_RDQ;
      ST_RDQ:  state_d = ST_RDP;
      ST_RDP:  state_d = ST_SCAN;
      ST_SCAN: state_d = (mask_q == '0) ? ST_POP : ST_CHK;
      ST_CHK:  state_d = col_vld_q[col_q] ? ST_SCAN : ST_AUGA;
      ST_AUGA: state_d = ST_AUGB;
      ST_AUGB: state_d = ST_AUGC;
      ST_AUGC: state_d = (par_rd_q == root_q[IdxW-1:0]) ? ST_ROOT : ST_AUGA;
      ST_DONE: if (!out_vld_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      n_q       <= '0;
      sz_mask_q <= '0;
      root_q    <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      rank_q    <= '0;
      cur_row_q <= '0;
      col_q     <= '0;
      mask_q    <= '0;
      vis_q     <= '0;
      row_vld_q <= '0;
      col_vld_q <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      state_q <= state_d;
      // drop a taken result unless a new one replaces it
      if (out_vld_q && out_ready_i && state_q != ST_DONE) out_vld_q <= 1'b0;
      if (pat_we) row_vld_q[in_data_i.row_index] <= 1'b1;
      case (state_q)
        ST_IDLE: begin
          if (in_acc && in_data_i.last_entry) begin
            n_q       <= eff_n;
            root_q    <= '0;
            rank_q    <= '0;
            col_vld_q <= '0;
            for (int i = 0; i < MaxSize; i++) begin
              sz_mask_q[i] <= (CntW'(i) < eff_n);
            end
          end
        end
        ST_ROOT: begin
          head_q <= '0;
          tail_q <= CntW'(1);
          vis_q  <= '0;
        end
        ST_POP: begin
          if (head_q != tail_q) head_q <= head_q + CntW'(1);
          else root_q <= root_q + CntW'(1);
        end
        ST_RDQ: cur_row_q <= que_rd_q;
        ST_RDP: begin
          mask_q <= (row_vld_q[cur_row_q] ? pat_rd_q : '0) & ~vis_q & sz_mask_q;
        end
        ST_SCAN: begin
          if (mask_q != '0) begin
            vis_q[scan_col]  <= 1'b1;
            mask_q[scan_col] <= 1'b0;
            col_q            <= scan_col;
          end
        end
        ST_CHK: begin
          if (col_vld_q[col_q]) tail_q <= tail_q + CntW'(1);
        end
        ST_AUGC: begin
          col_vld_q[col_q] <= 1'b1;
          if (par_rd_q == root_q[IdxW-1:0]) begin
            rank_q <= rank_q + CntW'(1);
            root_q <= root_q + CntW'(1);
          end else begin
            col_q <= rowm_rd_q;
          end
        end
        ST_DONE: begin
          if (!out_vld_q || out_ready_i) begin
            out_vld_q        <= 1'b1;
            out_q.rank       <= rank_q;
            out_q.deficiency <= n_q - rank_q;
            out_q.full_rank  <= (rank_q == n_q);
            row_vld_q        <= '0;
          end
        end
        default: ;
      endcase
    end
  end

`include "structural_rank_matching_unit_defines.svh"

  `SRM_ASSERT_IMP(a_busy_blocks_in, state_q != ST_IDLE, !in_ready_o, "input taken while busy")
  `SRM_ASSERT_IMP(a_rank_sum, out_vld_q, (out_q.rank + out_q.deficiency) <= CntW'(MaxSize), "rank sum")
  `SRM_ASSERT_IMP(a_full_def, out_vld_q && out_q.full_rank, out_q.deficiency == '0, "full rank")
  `SRM_ASSERT_IMP(a_queue_order, state_q != ST_IDLE, head_q <= tail_q, "queue overrun")
  `SRM_ASSERT_NXT(a_done_clears, state_q == ST_DONE && state_d == ST_IDLE, row_vld_q == '0,
                  "pattern not cleared")

endmodule
